// File: design/fpce_pkg.sv
// Package for the frustum plane culling engine: word layouts, action and verdict codes,
// register indexes and the saturating add. No dependencies.
`default_nettype none

package fpce_pkg;

  localparam int MAX_PLANES  = 32;
  localparam int PLANE_IDX_W = 5;
  localparam int COUNT_W     = 6;
  localparam int MARGIN_W    = 31;
  localparam int Q_W         = 32;
  localparam int FRAC_W      = 16;
  localparam int PROD_W      = 2 * Q_W - FRAC_W;
  localparam int SUM_W       = PROD_W + 2;
  localparam int THR_W       = Q_W + 1;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 32;

  localparam logic [COUNT_W-1:0]  PLANE_COUNT_RESET = COUNT_W'(6);
  localparam logic [MARGIN_W-1:0] MARGIN_RESET      = MARGIN_W'(3276800);
  localparam logic [COUNT_W-1:0]  MAX_PLANES_C      = COUNT_W'(MAX_PLANES);

  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REJECT_MARGIN = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ACT_WRITE_PLANE     = 3'd0,
    ACT_SET_MASK        = 3'd1,
    ACT_POINT           = 3'd2,
    ACT_SPHERE          = 3'd3,
    ACT_BOX_QUICK       = 3'd4,
    ACT_BOX_FULL        = 3'd5,
    ACT_BOX_SET_MASK    = 3'd6,
    ACT_BOX_UPDATE_MASK = 3'd7
  } action_e;

  localparam logic [1:0] VERDICT_OUTSIDE = 2'd0;
  localparam logic [1:0] VERDICT_PARTIAL = 2'd1;
  localparam logic [1:0] VERDICT_INSIDE  = 2'd2;

  typedef struct packed {
    logic [2:0]              action;
    logic [PLANE_IDX_W-1:0]  plane_slot;
    logic signed [Q_W-1:0]   value_a;
    logic signed [Q_W-1:0]   value_b;
    logic signed [Q_W-1:0]   value_c;
    logic signed [Q_W-1:0]   value_d;
    logic signed [Q_W-1:0]   value_e;
    logic signed [Q_W-1:0]   value_f;
    logic signed [Q_W-1:0]   shift_x;
    logic signed [Q_W-1:0]   shift_y;
    logic signed [Q_W-1:0]   shift_z;
    logic [31:0]             new_mask;
  } item_word_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [31:0] mask_now;
  } result_word_t;

  typedef struct packed {
    logic signed [Q_W-1:0] nx;
    logic signed [Q_W-1:0] ny;
    logic signed [Q_W-1:0] nz;
    logic signed [Q_W-1:0] distance;
  } plane_t;

  typedef struct packed {
    logic signed [Q_W-1:0] lo_x;
    logic signed [Q_W-1:0] lo_y;
    logic signed [Q_W-1:0] lo_z;
    logic signed [Q_W-1:0] hi_x;
    logic signed [Q_W-1:0] hi_y;
    logic signed [Q_W-1:0] hi_z;
  } box_t;

  typedef struct packed {
    logic                   valid;
    logic                   far;
    logic [PLANE_IDX_W-1:0] plane;
  } eval_tag_t;

  typedef struct packed {
    logic                   valid;
    logic                   far;
    logic [PLANE_IDX_W-1:0] plane;
    logic                   over;
  } eval_res_t;

  function automatic logic signed [Q_W-1:0] sat_add(input logic signed [Q_W-1:0] a,
                                                    input logic signed [Q_W-1:0] b);
    logic signed [Q_W:0] s;
    s = {a[Q_W-1], a} + {b[Q_W-1], b};
    if (s[Q_W] != s[Q_W-1]) begin
      sat_add = s[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
    end else begin
      sat_add = s[Q_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// File: design/fpce_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fpce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/fpce_dot.sv
// Shared plane evaluation unit: corner select, three Q16.16 products, sum and threshold
// compare over three registered stages. Depends on fpce_pkg.
`default_nettype none

module fpce_dot
  import fpce_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire eval_tag_t               tag_in,
  input  wire plane_t                  plane,
  input  wire box_t                    box,
  input  wire logic signed [THR_W-1:0] thr_near,
  output eval_res_t                    res,
  output logic                         busy
);

  eval_tag_t t1;
  eval_tag_t t2;
  eval_tag_t t3;

  logic signed [Q_W-1:0]    cx;
  logic signed [Q_W-1:0]    cy;
  logic signed [Q_W-1:0]    cz;
  logic signed [2*Q_W-1:0]  mx;
  logic signed [2*Q_W-1:0]  my;
  logic signed [2*Q_W-1:0]  mz;
  logic signed [PROD_W-1:0] px;
  logic signed [PROD_W-1:0] py;
  logic signed [PROD_W-1:0] pz;
  logic signed [Q_W-1:0]    plane_d;
  logic signed [SUM_W-1:0]  sum_c;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  thr;

  always_comb begin
    cx = ((!plane.nx[Q_W-1]) == t1.far) ? box.hi_x : box.lo_x;
    cy = ((!plane.ny[Q_W-1]) == t1.far) ? box.hi_y : box.lo_y;
    cz = ((!plane.nz[Q_W-1]) == t1.far) ? box.hi_z : box.lo_z;
    mx = cx * plane.nx;
    my = cy * plane.ny;
    mz = cz * plane.nz;
  end

  always_comb begin
    sum_c = {{2{px[PROD_W-1]}}, px} + {{2{py[PROD_W-1]}}, py} + {{2{pz[PROD_W-1]}}, pz}
          - {{(SUM_W-Q_W){plane_d[Q_W-1]}}, plane_d};
    thr   = t3.far ? '0 : {{(SUM_W-THR_W){thr_near[THR_W-1]}}, thr_near};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1.valid  <= 1'b0;
      t2.valid  <= 1'b0;
      t3.valid  <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      t1        <= tag_in;
      t2        <= t1;
      t3        <= t2;
      res.valid <= t3.valid;
    end
    px        <= mx[2*Q_W-1:FRAC_W];
    py        <= my[2*Q_W-1:FRAC_W];
    pz        <= mz[2*Q_W-1:FRAC_W];
    plane_d   <= plane.distance;
    sum       <= sum_c;
    res.far   <= t3.far;
    res.plane <= t3.plane;
    res.over  <= sum > thr;
  end

  assign busy = t1.valid | t2.valid | t3.valid | res.valid;

endmodule

`default_nettype wire

// File: design/frustum_plane_culling_engine_core.sv
// Top level of the frustum plane culling engine: sequencer, plane table, mask and result.
// Depends on fpce_pkg, fpce_ram and fpce_dot.
//
//   channel  direction  handshake          word
//   item     in         item_valid/stall   item_word_t
//   result   out        result_valid/stall result_word_t
//   cfg      in         cfg_valid/ready    cfg_index, cfg_data
//
// Write plane, set mask and a test with no planes in use go from acceptance straight to the
// finish state, which raises the result word. A test first makes one pass per plane in use,
// two for the full box test and set-from-box (near and far corner each take a pass of the
// shared multiplier unit). The next item is taken in the cycle after the word is raised.
// Reset is synchronous; it empties the pipeline, sets the mask to all ones and the registers
// to their defaults. The plane table is not cleared. The next item may arrive while a word is
// waiting; its own result word then holds the block in the finish state until that is taken.
`default_nettype none

module frustum_plane_culling_engine_core
  import fpce_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire item_word_t            item,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output result_word_t               result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ISSUE  = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t                  state;
  action_e                 act;
  box_t                    box;
  logic signed [THR_W-1:0] thr_near;
  logic [31:0]             mask;
  logic [COUNT_W-1:0]      plane_count;
  logic [MARGIN_W-1:0]     margin;
  logic [PLANE_IDX_W-1:0]  idx;
  logic                    phase;
  logic                    near_fail;
  logic                    far_fail;

  logic [COUNT_W-1:0]      n_planes;
  logic [COUNT_W-1:0]      n_minus;
  logic [PLANE_IDX_W-1:0]  last_idx;
  logic                    two_pass;
  logic                    accept;
  logic                    item_is_box;
  logic                    item_is_test;
  logic                    ram_we;
  plane_t                  ram_wdata;
  plane_t                  ram_rdata;
  eval_tag_t               tag0;
  eval_res_t               res;
  logic                    busy;
  logic [1:0]              verdict_c;

  assign item_stall   = (state != ST_IDLE);
  assign cfg_ready    = 1'b1;
  assign accept       = item_valid && (state == ST_IDLE);
  assign item_is_box  = item.action[2];
  assign item_is_test = (item.action != ACT_WRITE_PLANE) && (item.action != ACT_SET_MASK);

  assign n_planes = (plane_count > MAX_PLANES_C) ? MAX_PLANES_C : plane_count;
  assign n_minus  = n_planes - COUNT_W'(1);
  assign last_idx = n_minus[PLANE_IDX_W-1:0];
  assign two_pass = (act == ACT_BOX_FULL) || (act == ACT_BOX_SET_MASK);

  assign ram_we    = accept && (item.action == ACT_WRITE_PLANE)
                     && ({1'b0, item.plane_slot} < MAX_PLANES_C);
  assign ram_wdata = '{nx: item.value_a, ny: item.value_b, nz: item.value_c,
                       distance: item.value_d};

  assign tag0.valid = (state == ST_ISSUE);
  assign tag0.far   = two_pass ? phase : (act == ACT_BOX_UPDATE_MASK);
  assign tag0.plane = idx;

  fpce_ram #(
    .WIDTH ($bits(plane_t)),
    .DEPTH (MAX_PLANES)
  ) u_planes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (item.plane_slot),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  fpce_dot u_dot (
    .clk      (clk),
    .rst      (rst),
    .tag_in   (tag0),
    .plane    (ram_rdata),
    .box      (box),
    .thr_near (thr_near),
    .res      (res),
    .busy     (busy)
  );

  always_comb begin
    unique case (act)
      ACT_POINT, ACT_SPHERE, ACT_BOX_QUICK, ACT_BOX_SET_MASK: begin
        verdict_c = near_fail ? VERDICT_OUTSIDE : VERDICT_PARTIAL;
      end
      ACT_BOX_FULL: begin
        verdict_c = near_fail ? VERDICT_OUTSIDE : (far_fail ? VERDICT_PARTIAL : VERDICT_INSIDE);
      end
      default: begin
        verdict_c = VERDICT_OUTSIDE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      mask         <= '1;
      plane_count  <= PLANE_COUNT_RESET;
      margin       <= MARGIN_RESET;
      idx          <= '0;
      phase        <= 1'b0;
      near_fail    <= 1'b0;
      far_fail     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PLANE_COUNT) begin
          plane_count <= cfg_data[COUNT_W-1:0];
        end else if (cfg_index == CFG_REJECT_MARGIN) begin
          margin <= cfg_data[MARGIN_W-1:0];
        end
      end

      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      // Near corner of a plane always comes back before its far corner.
      if (res.valid && mask[res.plane]) begin
        unique case (act)
          ACT_BOX_SET_MASK: begin
            if (!near_fail) begin
              if (!res.far) begin
                if (res.over) begin
                  near_fail <= 1'b1;
                end
              end else if (!res.over) begin
                mask[res.plane] <= 1'b0;
              end
            end
          end
          ACT_BOX_UPDATE_MASK: begin
            if (!res.over) begin
              mask[res.plane] <= 1'b0;
            end
          end
          default: begin
            if (res.over) begin
              if (res.far) begin
                far_fail <= 1'b1;
              end else begin
                near_fail <= 1'b1;
              end
            end
          end
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            act       <= action_e'(item.action);
            near_fail <= 1'b0;
            far_fail  <= 1'b0;
            idx       <= '0;
            phase     <= 1'b0;
            box.lo_x  <= item_is_box ? sat_add(item.value_a, item.shift_x) : item.value_a;
            box.lo_y  <= item_is_box ? sat_add(item.value_b, item.shift_y) : item.value_b;
            box.lo_z  <= item_is_box ? sat_add(item.value_c, item.shift_z) : item.value_c;
            box.hi_x  <= item_is_box ? sat_add(item.value_d, item.shift_x) : item.value_a;
            box.hi_y  <= item_is_box ? sat_add(item.value_e, item.shift_y) : item.value_b;
            box.hi_z  <= item_is_box ? sat_add(item.value_f, item.shift_z) : item.value_c;
            if (item.action == ACT_SPHERE) begin
              thr_near <= {item.value_d[Q_W-1], item.value_d};
            end else if ((item.action == ACT_BOX_QUICK) || (item.action == ACT_BOX_FULL)) begin
              thr_near <= {2'b00, margin};
            end else begin
              thr_near <= '0;
            end
            if (item.action == ACT_SET_MASK) begin
              mask <= item.new_mask;
            end
            state <= (item_is_test && (n_planes != '0)) ? ST_ISSUE : ST_FINISH;
          end
        end
        ST_ISSUE: begin
          if (two_pass && !phase) begin
            phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            if (idx == last_idx) begin
              state <= ST_DRAIN;
            end else begin
              idx <= idx + PLANE_IDX_W'(1);
            end
          end
        end
        ST_DRAIN: begin
          if (!busy) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!result_valid || !result_stall) begin
            result_valid     <= 1'b1;
            result.verdict   <= verdict_c;
            result.mask_now  <= mask;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
